// ----- rtl/shp_pkg.sv -----
// Shared types, microcode codes and constant tables for the scrambled Halton point block.
// No dependencies; imported by shp_seq, shp_datapath and scrambled_halton_point.
`timescale 1ns / 1ps
`default_nettype none

package shp_pkg;

  localparam int DimW      = 6;
  localparam int IdxFieldW = 20;
  localparam int FracBits  = 32;
  localparam int PrimeW    = 8;
  localparam int DimsReset = 50;

  typedef struct packed {
    logic [IdxFieldW-1:0] sample_index;
    logic [DimW-1:0]      dimension;
  } in_item_t;

  typedef struct packed {
    logic [FracBits-1:0] fraction;
    logic                bad_dimension;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIVJ,
    OP_DSTEP,
    OP_SCR,
    OP_ACC,
    OP_FINIT,
    OP_FSTEP,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NEVER,
    C_NO_START,
    C_BAD,
    C_J_ZERO,
    C_CNT_MORE
  } cond_e;

  typedef struct packed {
    op_e op;
  } ctrl_t;

  typedef struct packed {
    logic bad;
    logic j_zero;
    logic cnt_more;
  } status_t;

  function automatic logic [PrimeW-1:0] prime_of(input logic [DimW-1:0] dim);
    logic [PrimeW-1:0] p;
    case (dim)
      6'd0:  p = 8'd2;    6'd1:  p = 8'd3;    6'd2:  p = 8'd5;    6'd3:  p = 8'd7;
      6'd4:  p = 8'd11;   6'd5:  p = 8'd13;   6'd6:  p = 8'd17;   6'd7:  p = 8'd19;
      6'd8:  p = 8'd23;   6'd9:  p = 8'd29;   6'd10: p = 8'd31;   6'd11: p = 8'd37;
      6'd12: p = 8'd41;   6'd13: p = 8'd43;   6'd14: p = 8'd47;   6'd15: p = 8'd53;
      6'd16: p = 8'd59;   6'd17: p = 8'd61;   6'd18: p = 8'd67;   6'd19: p = 8'd71;
      6'd20: p = 8'd73;   6'd21: p = 8'd79;   6'd22: p = 8'd83;   6'd23: p = 8'd89;
      6'd24: p = 8'd97;   6'd25: p = 8'd101;  6'd26: p = 8'd103;  6'd27: p = 8'd107;
      6'd28: p = 8'd109;  6'd29: p = 8'd113;  6'd30: p = 8'd127;  6'd31: p = 8'd131;
      6'd32: p = 8'd137;  6'd33: p = 8'd139;  6'd34: p = 8'd149;  6'd35: p = 8'd151;
      6'd36: p = 8'd157;  6'd37: p = 8'd163;  6'd38: p = 8'd167;  6'd39: p = 8'd173;
      6'd40: p = 8'd179;  6'd41: p = 8'd181;  6'd42: p = 8'd191;  6'd43: p = 8'd193;
      6'd44: p = 8'd197;  6'd45: p = 8'd199;  6'd46: p = 8'd211;  6'd47: p = 8'd223;
      6'd48: p = 8'd227;  6'd49: p = 8'd229;
      default: p = 8'd2;
    endcase
    return p;
  endfunction

  function automatic logic [PrimeW-1:0] weight_of(input logic [DimW-1:0] dim);
    logic [PrimeW-1:0] w;
    case (dim)
      6'd0:  w = 8'd1;    6'd1:  w = 8'd2;    6'd2:  w = 8'd2;    6'd3:  w = 8'd5;
      6'd4:  w = 8'd3;    6'd5:  w = 8'd7;    6'd6:  w = 8'd3;    6'd7:  w = 8'd10;
      6'd8:  w = 8'd18;   6'd9:  w = 8'd11;   6'd10: w = 8'd17;   6'd11: w = 8'd5;
      6'd12: w = 8'd17;   6'd13: w = 8'd26;   6'd14: w = 8'd40;   6'd15: w = 8'd14;
      6'd16: w = 8'd40;   6'd17: w = 8'd44;   6'd18: w = 8'd12;   6'd19: w = 8'd31;
      6'd20: w = 8'd45;   6'd21: w = 8'd70;   6'd22: w = 8'd8;    6'd23: w = 8'd38;
      6'd24: w = 8'd82;   6'd25: w = 8'd8;    6'd26: w = 8'd12;   6'd27: w = 8'd38;
      6'd28: w = 8'd47;   6'd29: w = 8'd70;   6'd30: w = 8'd29;   6'd31: w = 8'd57;
      6'd32: w = 8'd97;   6'd33: w = 8'd110;  6'd34: w = 8'd32;   6'd35: w = 8'd48;
      6'd36: w = 8'd84;   6'd37: w = 8'd124;  6'd38: w = 8'd155;  6'd39: w = 8'd26;
      6'd40: w = 8'd69;   6'd41: w = 8'd83;   6'd42: w = 8'd157;  6'd43: w = 8'd171;
      6'd44: w = 8'd8;    6'd45: w = 8'd32;   6'd46: w = 8'd112;  6'd47: w = 8'd205;
      6'd48: w = 8'd15;   6'd49: w = 8'd31;
      default: w = 8'd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/shp_seq.sv -----
// Microcode sequencer: step counter, control-word ROM and conditional jumps.
// Depends on shp_pkg (op and condition codes, ctrl_t, status_t).
`timescale 1ns / 1ps
`default_nettype none

module shp_seq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  input  shp_pkg::status_t     status_i,
  output shp_pkg::ctrl_t       ctrl_o,
  output logic                 busy
);
  import shp_pkg::*;

  typedef logic [3:0] pc_t;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } uword_t;

  localparam pc_t PcIdle  = 4'd0;
  localparam pc_t PcCheck = 4'd1;
  localparam pc_t PcLoop  = 4'd2;
  localparam pc_t PcDiv1  = 4'd3;
  localparam pc_t PcScr   = 4'd4;
  localparam pc_t PcDiv2  = 4'd5;
  localparam pc_t PcAcc   = 4'd6;
  localparam pc_t PcFinit = 4'd7;
  localparam pc_t PcFstep = 4'd8;
  localparam pc_t PcDone  = 4'd9;

  function automatic uword_t ucode(input pc_t pc);
    uword_t u;
    case (pc)
      PcIdle:  u = '{op: OP_LOAD,  cond: C_NO_START, target: PcIdle};
      PcCheck: u = '{op: OP_NONE,  cond: C_BAD,      target: PcDone};
      PcLoop:  u = '{op: OP_DIVJ,  cond: C_J_ZERO,   target: PcFinit};
      PcDiv1:  u = '{op: OP_DSTEP, cond: C_CNT_MORE, target: PcDiv1};
      PcScr:   u = '{op: OP_SCR,   cond: C_NEVER,    target: PcIdle};
      PcDiv2:  u = '{op: OP_DSTEP, cond: C_CNT_MORE, target: PcDiv2};
      PcAcc:   u = '{op: OP_ACC,   cond: C_ALWAYS,   target: PcLoop};
      PcFinit: u = '{op: OP_FINIT, cond: C_NEVER,    target: PcIdle};
      PcFstep: u = '{op: OP_FSTEP, cond: C_CNT_MORE, target: PcFstep};
      PcDone:  u = '{op: OP_EMIT,  cond: C_ALWAYS,   target: PcIdle};
      default: u = '{op: OP_NONE,  cond: C_ALWAYS,   target: PcIdle};
    endcase
    return u;
  endfunction

  pc_t    pc_q, pc_d;
  uword_t uw;
  logic   taken;

  always_comb begin
    uw = ucode(pc_q);
    case (uw.cond)
      C_ALWAYS:   taken = 1'b1;
      C_NEVER:    taken = 1'b0;
      C_NO_START: taken = !start;
      C_BAD:      taken = status_i.bad;
      C_J_ZERO:   taken = status_i.j_zero;
      C_CNT_MORE: taken = status_i.cnt_more;
      default:    taken = 1'b0;
    endcase
    pc_d = taken ? uw.target : pc_t'(pc_q + 4'd1);
    ctrl_o.op = taken && (uw.cond == C_NO_START) ? OP_NONE : uw.op;
    busy = (pc_q != PcIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PcIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= PcDone)
    else $error("sequencer left its program");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (pc_q == PcCheck))
    else $error("accepted item did not enter the check step");

  a_emit_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == PcDone) |=> !busy)
    else $error("emit step did not return to idle");

endmodule

`default_nettype wire

// ----- rtl/shp_datapath.sv -----
// Datapath: shared bit-serial divider by the prime base, digit scrambling, numerator and
// denominator accumulation, fractional long division and the result register.
// Depends on shp_pkg (items, ctrl_t, status_t, prime and weight tables).
`timescale 1ns / 1ps
`default_nettype none

module shp_datapath #(
  parameter int IndexBits = 20,
  parameter int TableDims = 50
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [shp_pkg::DimW-1:0] cfg_wdata_i,
  input  shp_pkg::in_item_t            item_i,
  input  shp_pkg::ctrl_t               ctrl_i,
  output shp_pkg::status_t             status_o,
  output shp_pkg::out_item_t           result_o,
  output logic                         out_valid_o
);
  import shp_pkg::*;

  localparam int DivW  = (IndexBits > 16) ? IndexBits : 16;
  localparam int NumW  = IndexBits + PrimeW;
  localparam int CntMx = (DivW > FracBits) ? DivW : FracBits;
  localparam int CntW  = $clog2(CntMx + 1);
  localparam logic [DimW:0] DimLimit = (DimW + 1)'(TableDims);

  logic [IndexBits-1:0] j_q, j_d;
  logic [PrimeW-1:0]    p_q, p_d, w_q, w_d, rmd_q, rmd_d;
  logic                 bad_q, bad_d;
  logic [DivW-1:0]      dvd_q, dvd_d;
  logic [NumW-1:0]      num_q, num_d, den_q, den_d, frem_q, frem_d;
  logic [FracBits-1:0]  q_q, q_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  out_item_t            res_q, res_d;
  logic                 vld_q;
  logic [DimW-1:0]      dims_q;

  logic [PrimeW:0]       t, tsub;
  logic                  t_ge;
  logic [2*PrimeW-1:0]   scr_prod;
  logic [NumW+PrimeW-1:0] num_mul, den_mul;
  logic [NumW:0]         r2, fsub;
  logic                  f_ge;

  always_comb begin
    t        = {rmd_q, dvd_q[DivW-1]};
    tsub     = t - {1'b0, p_q};
    t_ge     = (t >= {1'b0, p_q});
    scr_prod = (2 * PrimeW)'(rmd_q) * (2 * PrimeW)'(w_q);
    num_mul  = (NumW + PrimeW)'(num_q) * (NumW + PrimeW)'(p_q);
    den_mul  = (NumW + PrimeW)'(den_q) * (NumW + PrimeW)'(p_q);
    r2       = {frem_q, 1'b0};
    fsub     = r2 - {1'b0, den_q};
    f_ge     = (r2 >= {1'b0, den_q});

    j_d    = j_q;
    p_d    = p_q;
    w_d    = w_q;
    bad_d  = bad_q;
    dvd_d  = dvd_q;
    rmd_d  = rmd_q;
    num_d  = num_q;
    den_d  = den_q;
    frem_d = frem_q;
    q_d    = q_q;
    cnt_d  = cnt_q;
    res_d  = res_q;

    case (ctrl_i.op)
      OP_LOAD: begin
        j_d   = IndexBits'(item_i.sample_index);
        p_d   = prime_of(item_i.dimension);
        w_d   = weight_of(item_i.dimension);
        bad_d = (item_i.dimension >= dims_q) || ({1'b0, item_i.dimension} >= DimLimit);
        num_d = '0;
        den_d = NumW'(1);
      end
      OP_DIVJ: begin
        dvd_d = DivW'(j_q);
        rmd_d = '0;
        cnt_d = CntW'(DivW);
      end
      OP_DSTEP: begin
        dvd_d = {dvd_q[DivW-2:0], t_ge};
        rmd_d = t_ge ? tsub[PrimeW-1:0] : t[PrimeW-1:0];
        cnt_d = cnt_q - CntW'(1);
      end
      OP_SCR: begin
        j_d   = dvd_q[IndexBits-1:0];
        dvd_d = DivW'(scr_prod);
        rmd_d = '0;
        cnt_d = CntW'(DivW);
      end
      OP_ACC: begin
        num_d = NumW'(num_mul + (NumW + PrimeW)'(rmd_q));
        den_d = NumW'(den_mul);
      end
      OP_FINIT: begin
        frem_d = num_q;
        q_d    = '0;
        cnt_d  = CntW'(FracBits);
      end
      OP_FSTEP: begin
        frem_d = f_ge ? fsub[NumW-1:0] : r2[NumW-1:0];
        q_d    = {q_q[FracBits-2:0], f_ge};
        cnt_d  = cnt_q - CntW'(1);
      end
      OP_EMIT: begin
        res_d.fraction      = bad_q ? '0 : q_q;
        res_d.bad_dimension = bad_q;
      end
      default: ;
    endcase

    status_o.bad      = bad_q;
    status_o.j_zero   = (j_q == '0);
    status_o.cnt_more = (cnt_q != CntW'(1));
  end

  always_ff @(posedge clk_i) begin
    j_q    <= j_d;
    p_q    <= p_d;
    w_q    <= w_d;
    bad_q  <= bad_d;
    dvd_q  <= dvd_d;
    rmd_q  <= rmd_d;
    num_q  <= num_d;
    den_q  <= den_d;
    frem_q <= frem_d;
    q_q    <= q_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      dims_q <= DimW'(DimsReset);
    end else begin
      vld_q <= (ctrl_i.op == OP_EMIT);
      if (cfg_we_i) begin
        dims_q <= cfg_wdata_i;
      end
    end
  end

  assign result_o    = res_q;
  assign out_valid_o = vld_q;

  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == OP_DSTEP || ctrl_i.op == OP_FSTEP) |-> (cnt_q != '0))
    else $error("division step ran past its count");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(ctrl_i.op) == OP_FSTEP) |-> (frem_q < den_q))
    else $error("fraction remainder not below denominator");

  a_digit_below_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == OP_ACC) |-> (rmd_q < p_q))
    else $error("scrambled digit not below base");

endmodule

`default_nettype wire

// ----- rtl/scrambled_halton_point.sv -----
// Top level of the scrambled Halton point generator: microcode sequencer plus datapath.
// Depends on shp_pkg, shp_seq and shp_datapath.
//
//   channel   ports                          handshake
//   config    cfg_we_i, cfg_wdata_i          written when cfg_we_i is high
//   item in   item_i, start, busy            accepted when start && !busy
//   result    result_o, out_valid_o          one-cycle strobe, always taken
//
// Each item runs, from acceptance: a check step, then for each of the k base-p digits of the
// index a bit-serial divide by the base of D = max(IndexBits, 16) steps, which runs twice
// per digit (digit split and scramble reduction), then a loop exit step, the 32-step
// fractional division and an emit step, before the sequencer returns to idle.
// A flagged dimension goes from the check step straight to the emit step.
// Reset clears the sequencer to idle and dims_q to 50. The result appears the cycle
// after the item's last step, while busy is already low; it is never stalled.
`timescale 1ns / 1ps
`default_nettype none

module scrambled_halton_point #(
  parameter int IndexBits = 20,
  parameter int TableDims = 50
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [shp_pkg::DimW-1:0] cfg_wdata_i,
  input  wire logic                     start,
  output logic                          busy,
  input  shp_pkg::in_item_t             item_i,
  output shp_pkg::out_item_t            result_o,
  output logic                          out_valid_o
);
  import shp_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  shp_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy     (busy)
  );

  shp_datapath #(
    .IndexBits (IndexBits),
    .TableDims (TableDims)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .result_o    (result_o),
    .out_valid_o (out_valid_o)
  );

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(busy))
    else $error("result without an item in flight");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o)
    else $error("two results for one item");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_o.bad_dimension) |-> (result_o.fraction == '0))
    else $error("flagged item with nonzero fraction");

endmodule

`default_nettype wire
